[rtl/nll_pkg.sv]
// ----------------------------------------------------------------------------
// nll_pkg: shared types, constants and functions of the ladder lowpass
// Q8.24 constants, sequencer states, register indexes, saturating helpers
// and the elaboration-time tanh table generator.
// ----------------------------------------------------------------------------
package nll_pkg;

    localparam int unsigned TANH_TABLE_DEPTH_DEF = 256;
    localparam int unsigned STAGE_COUNT          = 4;

    localparam int unsigned ONE_Q24  = 32'd16777216;
    localparam int unsigned HALF_Q24 = 32'd8388608;
    localparam int unsigned FOUR_Q24 = 32'd67108864;
    localparam int unsigned SPAN_Q24 = 32'd58720256;   // 3.5 = 7 * 2^23

    // ceil(2^32 / 7): exact floor division by 7 for operands below 2^30
    localparam logic [29:0] RECIP7 = 30'd613566757;

    localparam int unsigned MUL_W  = 33;
    localparam int unsigned PROD_W = 66;

    typedef enum logic [1:0] {
        REG_STAGE_GAIN    = 2'd0,
        REG_FEEDBACK_GAIN = 2'd1,
        REG_DRIVE_GAIN    = 2'd2,
        REG_UNUSED        = 2'd3
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_X,
        ST_ST0,
        ST_ACC,
        ST_SVK,
        ST_W3,
        ST_DONE,
        ST_SAT_A,
        ST_SAT_D,
        ST_SAT_I,
        ST_SAT_F,
        ST_SAT_R
    } state_t;

    // saturate a 34-bit signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sh0_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -34'sh0_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Q8.24 product: floor shift by 24, then saturate
    function automatic logic signed [31:0] mulq(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        logic signed [31:0] r;
        s = p >>> 24;
        if (s > 66'sh7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (s < -66'sh8000_0000)
            r = 32'sh8000_0000;
        else
            r = s[31:0];
        return r;
    endfunction

    function automatic longint unsigned mul_q28(input longint unsigned a,
                                                input longint unsigned b);
        longint unsigned mask;
        mask = (64'd1 << 28) - 64'd1;
        return (a >> 28) * b + (((a & mask) * b) >> 28);
    endfunction

    // long division of constants, evaluated at elaboration only
    function automatic longint unsigned const_udiv(input longint unsigned n,
                                                   input longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = 64'd0;
        r = 64'd0;
        for (int b = 63; b >= 0; b--)
        begin
            r = (r << 1) | ((n >> b) & 64'd1);
            if (r >= d)
            begin
                r = r - d;
                q = q | (64'd1 << b);
            end
        end
        return q;
    endfunction

    // tanh table entry i, evaluated at elaboration only
    function automatic logic [31:0] tanh_entry(input int unsigned i,
                                               input int unsigned depth);
        longint unsigned off;
        longint unsigned y;
        longint unsigned whole;
        longint unsigned f;
        longint unsigned term;
        longint unsigned e;
        longint unsigned dv;
        longint unsigned q;
        off   = const_udiv(64'(i) * 64'(SPAN_Q24), 64'(depth));
        y     = (HALF_Q24 + off) * 64'd2;
        whole = y >> 24;
        f     = y & 64'hFF_FFFF;
        term  = 64'd1 << 28;
        e     = term;
        for (int j = 1; j <= 14; j++)
        begin
            term = const_udiv((term * f) >> 24, 64'(j));
            e    = e + term;
        end
        for (int j = 0; j < 9; j++)
        begin
            if (j < whole)
                e = mul_q28(e, 64'd729683223);
        end
        dv = e + (64'd1 << 28);
        q  = const_udiv((64'd1 << 53) + (dv >> 1), dv);
        return 32'(longint'(ONE_Q24) - q);
    endfunction

endpackage

[rtl/nonlinear_ladder_lowpass_top.sv]
// ----------------------------------------------------------------------------
// nonlinear_ladder_lowpass_top: four-stage nonlinear ladder lowpass
// Sequencer around one shared multiplier; per-stage tanh saturator from a
// constant interpolation table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / sample_in) takes one signed Q8.24
//   sample per beat. Output channel (out_valid / out_stall / sample_out)
//   returns one filtered Q8.24 sample per input beat, in order.
//   Coefficients arrive on the write port (cfg_we, cfg_index, cfg_data):
//   index 0 stage gain, 1 feedback gain, 2 drive gain; index 3 is dropped.
//   Write them only while the filter is idle.
// Sequencing:
//   Every multiply goes through the single shared multiplier, one per
//   cycle. A saturator call ends in ST_SAT_A when the input is in the
//   linear or clipped region and runs through ST_SAT_A, ST_SAT_D, ST_SAT_I,
//   ST_SAT_F and ST_SAT_R on the table path; there are five saturator
//   calls per item. in_stall stays high until the item is handed to the
//   output register; the next beat may enter while that result still
//   waits on the output.
// Reset:
//   rst_n clears the filter state to zero and loads the default gains
//   (stage 1.0, feedback 0, drive 1.0). No clearing pass is needed.
// Output stall:
//   The result holds in the output register while out_stall is high; a
//   finished item behind it waits in its last state until the slot frees.
// ----------------------------------------------------------------------------
module nonlinear_ladder_lowpass_top #(
    parameter int unsigned TANH_TABLE_DEPTH = nll_pkg::TANH_TABLE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [30:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] sample_in,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] sample_out
);

    localparam int unsigned IW = $clog2(TANH_TABLE_DEPTH + 1);
    localparam int unsigned MW = nll_pkg::MUL_W;
    localparam int unsigned PW = nll_pkg::PROD_W;

    // interpolation table, built at elaboration
    logic signed [31:0] tanh_tab [0:TANH_TABLE_DEPTH];

    for (genvar g = 0; g <= TANH_TABLE_DEPTH; g++)
    begin : g_tab
        localparam logic [31:0] ENTRY = nll_pkg::tanh_entry(g, TANH_TABLE_DEPTH);
        assign tanh_tab[g] = ENTRY;
    end

    // configuration
    logic [30:0] stage_gain_reg;
    logic [30:0] feedback_gain_reg;
    logic [30:0] drive_gain_reg;

    // filter state
    logic signed [31:0] stage_reg [0:3];
    logic signed [31:0] satv_reg  [0:2];
    logic signed [31:0] prev_reg;
    logic signed [31:0] avg_reg;

    // sequencer
    nll_pkg::state_t state_reg, state_next;
    nll_pkg::state_t ret_reg;
    logic [1:0]      k_reg;

    // working registers
    logic signed [31:0] xin_reg;
    logic signed [31:0] sat_res_reg;
    logic               sat_neg_reg;
    logic [39:0]        d_reg;
    logic signed [31:0] lo_reg;

    logic signed [31:0] out_data_reg;
    logic               out_valid_reg;

    // multiplier
    logic                 mul_en;
    logic signed [MW-1:0] mul_a;
    logic signed [MW-1:0] mul_b;
    logic signed [PW-1:0] prod;

    nll_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // shared datapath terms
    logic signed [31:0] prod_q;
    logic signed [31:0] x_val;
    logic signed [31:0] acc_val;
    logic [31:0]        abs_a;
    logic               a_neg;
    logic [IW-1:0]      idx;
    logic [16:0]        q_raw;
    logic [39:0]        rem;
    logic signed [31:0] tab_lo;
    logic signed [31:0] tab_hi;
    logic signed [31:0] interp;
    logic signed [31:0] diff_k;
    logic signed [31:0] diff_w3;
    logic signed [31:0] diff_0;
    logic signed [32:0] avg_sum;
    logic               in_accept;
    logic               out_free;

    assign prod_q    = nll_pkg::mulq(prod);
    assign x_val     = nll_pkg::sat32(34'(xin_reg) - 34'(prod_q));
    assign acc_val   = nll_pkg::sat32(34'(stage_reg[k_reg]) + 34'(prod_q));
    assign a_neg     = prod_q[31];
    assign abs_a     = a_neg ? (32'd0 - 32'(prod_q)) : 32'(prod_q);
    assign q_raw     = prod[48:32];
    assign idx       = (q_raw >= 17'(TANH_TABLE_DEPTH)) ? IW'(TANH_TABLE_DEPTH - 1)
                                                        : IW'(q_raw);
    assign rem       = d_reg - ((40'(idx) * 40'd7) << 23);
    assign tab_lo    = tanh_tab[idx];
    assign tab_hi    = tanh_tab[idx + IW'(1)];
    assign interp    = lo_reg + 32'(prod[63:32]);
    assign diff_0    = nll_pkg::sat32(34'(sat_res_reg) - 34'(satv_reg[0]));
    assign diff_k    = nll_pkg::sat32(34'(sat_res_reg) - 34'(satv_reg[k_reg]));
    assign diff_w3   = nll_pkg::sat32(34'(satv_reg[2]) - 34'(sat_res_reg));
    assign avg_sum   = 33'(stage_reg[3]) + 33'(prev_reg);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign in_stall   = (state_reg != nll_pkg::ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign sample_out = out_data_reg;

    // next state and multiplier operands
    always_comb
    begin
        state_next = state_reg;
        mul_en     = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        unique case (state_reg)
            nll_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    mul_en     = 1'b1;
                    mul_a      = MW'(avg_reg);
                    mul_b      = MW'({1'b0, feedback_gain_reg});
                    state_next = nll_pkg::ST_X;
                end
            end
            nll_pkg::ST_X:
            begin
                mul_en     = 1'b1;
                mul_a      = MW'(x_val);
                mul_b      = MW'({1'b0, drive_gain_reg});
                state_next = nll_pkg::ST_SAT_A;
            end
            nll_pkg::ST_ST0:
            begin
                mul_en     = 1'b1;
                mul_a      = MW'(diff_0);
                mul_b      = MW'({1'b0, stage_gain_reg});
                state_next = nll_pkg::ST_ACC;
            end
            nll_pkg::ST_ACC:
            begin
                if (k_reg == 2'd3)
                    state_next = nll_pkg::ST_DONE;
                else
                begin
                    mul_en     = 1'b1;
                    mul_a      = MW'(acc_val);
                    mul_b      = MW'({1'b0, drive_gain_reg});
                    state_next = nll_pkg::ST_SAT_A;
                end
            end
            nll_pkg::ST_SVK:
            begin
                mul_en = 1'b1;
                if (k_reg == 2'd3)
                begin
                    mul_a      = MW'(stage_reg[3]);
                    mul_b      = MW'({1'b0, drive_gain_reg});
                    state_next = nll_pkg::ST_SAT_A;
                end
                else
                begin
                    mul_a      = MW'(diff_k);
                    mul_b      = MW'({1'b0, stage_gain_reg});
                    state_next = nll_pkg::ST_ACC;
                end
            end
            nll_pkg::ST_W3:
            begin
                mul_en     = 1'b1;
                mul_a      = MW'(diff_w3);
                mul_b      = MW'({1'b0, stage_gain_reg});
                state_next = nll_pkg::ST_ACC;
            end
            nll_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = nll_pkg::ST_IDLE;
            end
            nll_pkg::ST_SAT_A:
            begin
                if (abs_a >= nll_pkg::FOUR_Q24 || abs_a < nll_pkg::HALF_Q24)
                    state_next = ret_reg;
                else
                begin
                    mul_en     = 1'b1;
                    mul_a      = MW'(abs_a - nll_pkg::HALF_Q24);
                    mul_b      = MW'(TANH_TABLE_DEPTH);
                    state_next = nll_pkg::ST_SAT_D;
                end
            end
            nll_pkg::ST_SAT_D:
            begin
                mul_en     = 1'b1;
                mul_a      = MW'(prod[39:23]);
                mul_b      = MW'(nll_pkg::RECIP7);
                state_next = nll_pkg::ST_SAT_I;
            end
            nll_pkg::ST_SAT_I:
            begin
                mul_en     = 1'b1;
                mul_a      = MW'(tab_hi - tab_lo);
                mul_b      = MW'(rem[26:0]);
                state_next = nll_pkg::ST_SAT_F;
            end
            nll_pkg::ST_SAT_F:
            begin
                mul_en     = 1'b1;
                mul_a      = MW'(prod[50:23]);
                mul_b      = MW'(nll_pkg::RECIP7);
                state_next = nll_pkg::ST_SAT_R;
            end
            nll_pkg::ST_SAT_R:
            begin
                state_next = ret_reg;
            end
            default:
            begin
                state_next = nll_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= nll_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // control and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_gain_reg    <= 31'(nll_pkg::ONE_Q24);
            feedback_gain_reg <= '0;
            drive_gain_reg    <= 31'(nll_pkg::ONE_Q24);
            for (int i = 0; i < 4; i++)
                stage_reg[i] <= '0;
            for (int i = 0; i < 3; i++)
                satv_reg[i] <= '0;
            prev_reg      <= '0;
            avg_reg       <= '0;
            k_reg         <= '0;
            ret_reg       <= nll_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (nll_pkg::reg_index_t'(cfg_index))
                    nll_pkg::REG_STAGE_GAIN:    stage_gain_reg    <= cfg_data;
                    nll_pkg::REG_FEEDBACK_GAIN: feedback_gain_reg <= cfg_data;
                    nll_pkg::REG_DRIVE_GAIN:    drive_gain_reg    <= cfg_data;
                    default:                    ;
                endcase
            end

            // load a finished beat, drop the output beat once taken
            if (state_reg == nll_pkg::ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                nll_pkg::ST_X:
                begin
                    k_reg   <= 2'd0;
                    ret_reg <= nll_pkg::ST_ST0;
                end
                nll_pkg::ST_ACC:
                begin
                    stage_reg[k_reg] <= acc_val;
                    if (k_reg != 2'd3)
                    begin
                        k_reg   <= k_reg + 2'd1;
                        ret_reg <= nll_pkg::ST_SVK;
                    end
                end
                nll_pkg::ST_SVK:
                begin
                    satv_reg[k_reg - 2'd1] <= sat_res_reg;
                    if (k_reg == 2'd3)
                        ret_reg <= nll_pkg::ST_W3;
                end
                nll_pkg::ST_DONE:
                begin
                    if (out_free)
                    begin
                        avg_reg  <= avg_sum[32:1];
                        prev_reg <= stage_reg[3];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // working payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
            xin_reg <= sample_in;
        if (state_reg == nll_pkg::ST_DONE && out_free)
            out_data_reg <= avg_sum[32:1];
        unique case (state_reg)
            nll_pkg::ST_SAT_A:
            begin
                sat_neg_reg <= a_neg;
                if (abs_a >= nll_pkg::FOUR_Q24)
                    sat_res_reg <= a_neg ? -32'(nll_pkg::ONE_Q24) : 32'(nll_pkg::ONE_Q24);
                else
                    sat_res_reg <= prod_q;
            end
            nll_pkg::ST_SAT_D:
                d_reg <= prod[39:0];
            nll_pkg::ST_SAT_I:
                lo_reg <= tab_lo;
            nll_pkg::ST_SAT_R:
                sat_res_reg <= sat_neg_reg ? -interp : interp;
            default:
            begin
            end
        endcase
    end

endmodule

[rtl/nll_mul.sv]
// ----------------------------------------------------------------------------
// nll_mul: shared signed multiplier
// One 33 x 33 signed multiply per cycle into a registered product.
// ----------------------------------------------------------------------------
module nll_mul (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [nll_pkg::MUL_W-1:0]     a,
    input  logic signed [nll_pkg::MUL_W-1:0]     b,
    output logic signed [nll_pkg::PROD_W-1:0]    prod
);

    logic signed [nll_pkg::PROD_W-1:0] prod_reg;

    // hold the product until the next load
    always_ff @(posedge clk)
    begin
        if (en)
            prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule
